// File: hdl/mm3_pkg.sv
// shared constants, types and helpers for the murmur3 32-bit hash block
`default_nettype none

package mm3_pkg;

   // mixing constants
   localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2  = 32'h1b873593;
   localparam logic [31:0] MM_ADD = 32'he6546b64;
   localparam logic [31:0] MM_F1  = 32'h85ebca6b;
   localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

   // byte counts
   localparam logic [2:0] FULL_BYTES = 3'd4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // word class as seen by the back end
   typedef enum logic [1:0] {
      KIND_EMPTY,
      KIND_PART,
      KIND_FULL
   } mm3_kind_type;

   // one scrambled request on its way to the back end
   typedef struct packed {
      logic [31:0]  k;
      logic [2:0]   nbytes;
      mm3_kind_type kind;
      logic         done;
   } mm3_item_type;

   // back end sequencer
   typedef enum logic [1:0] {
      ST_RUN,
      ST_MIX1,
      ST_MIX2,
      ST_EMIT
   } mm3_state_type;

   // keep only the valid low bytes of a word
   function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
      logic [31:0] m;
      begin
         case (nbytes)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
         endcase
         return m;
      end
   endfunction

endpackage

`default_nettype wire

// File: hdl/mm3_front.sv
// front end: accepts request words, classifies them and scrambles the key word
`default_nettype none

module mm3_front
   import mm3_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [31:0]  req_data_word,
   input  wire logic [2:0]   req_byte_count,
   input  wire logic         req_last,
   output logic              push_valid,
   input  wire logic         push_ready,
   output mm3_item_type      push_item
);

   logic         s1_valid_ff, s1_valid_in;
   mm3_item_type s1_item_ff, s1_item_in;
   logic         s2_valid_ff, s2_valid_in;
   mm3_item_type s2_item_ff, s2_item_in;
   logic         adv1, adv2;
   logic [2:0]   nbytes;
   mm3_kind_type kind;
   logic [31:0]  rot15;

   // stage advance, a stage loads when empty or draining
   assign adv2      = !s2_valid_ff || push_ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   // clamp the count and classify the word
   always_comb begin
      nbytes = (req_byte_count > FULL_BYTES) ? FULL_BYTES : req_byte_count;
      case (nbytes)
         3'd0:       kind = KIND_EMPTY;
         FULL_BYTES: kind = KIND_FULL;
         default:    kind = KIND_PART;
      endcase
   end

   // stage one: mask and first multiply
   always_comb begin
      s1_item_in.k      = (req_data_word & byte_mask(nbytes)) * MM_C1;
      s1_item_in.nbytes = nbytes;
      s1_item_in.kind   = kind;
      s1_item_in.done   = req_last || (kind == KIND_PART);
      s1_valid_in       = adv1 ? req_valid : s1_valid_ff;
   end

   // stage two: rotate and second multiply
   always_comb begin
      rot15           = {s1_item_ff.k[16:0], s1_item_ff.k[31:17]};
      s2_item_in      = s1_item_ff;
      s2_item_in.k    = rot15 * MM_C2;
      s2_valid_in     = adv2 ? s1_valid_ff : s2_valid_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_item_ff <= s1_item_in;
      end
      if (adv2) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign push_valid = s2_valid_ff;
   assign push_item  = s2_item_ff;

endmodule

`default_nettype wire

// File: hdl/mm3_queue.sv
// short request queue that decouples the front end from the back end
`default_nettype none

module mm3_queue
   import mm3_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire mm3_item_type  push_item,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output mm3_item_type       pop_item
);

   mm3_item_type                 mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                         push_fire, pop_fire;

   // flags from the registered fill count
   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mm3_back.sv
// back end: hash recurrence, final avalanche and the response register
`default_nettype none

module mm3_back
   import mm3_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [31:0]   seed,
   input  wire logic          pop_valid,
   output logic               pop_ready,
   input  wire mm3_item_type  pop_item,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [31:0]        rsp_hash_value,
   output logic [31:0]        rsp_key_length
);

   mm3_state_type state_ff, state_in;
   logic          in_key_ff, in_key_in;
   logic [31:0]   hash_ff, total_ff, fin_ff, fin_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_hash_ff, rsp_len_ff;
   logic          pop_fire, slot_free, emit_load;
   logic [31:0]   base_h, base_t, new_h, new_t, mixed, rot13, fold, fin_shift;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop_fire  = pop_valid && pop_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN:  if (pop_valid && pop_item.done) state_in = ST_MIX1;
         ST_MIX1: state_in = ST_MIX2;
         ST_MIX2: state_in = ST_EMIT;
         ST_EMIT: if (slot_free) state_in = ST_RUN;
         default: state_in = ST_RUN;
      endcase
   end

   // sequencer outputs
   always_comb begin
      pop_ready = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         ST_RUN:  pop_ready = 1'b1;
         ST_EMIT: emit_load = slot_free;
         default: ;
      endcase
   end

   // one word into the running hash, seed at key start
   always_comb begin
      base_h = in_key_ff ? hash_ff : seed;
      base_t = in_key_ff ? total_ff : '0;
      new_t  = base_t + {29'd0, pop_item.nbytes};
      mixed  = base_h ^ pop_item.k;
      rot13  = {mixed[18:0], mixed[31:19]};
      case (pop_item.kind)
         KIND_FULL: new_h = rot13 + {rot13[29:0], 2'b00} + MM_ADD;
         KIND_PART: new_h = mixed;
         default:   new_h = base_h;
      endcase
      fold      = new_h ^ new_t;
      in_key_in = pop_fire ? !pop_item.done : in_key_ff;
   end

   // avalanche steps, one multiply in each mix state
   always_comb begin
      fin_shift = fin_ff ^ {13'd0, fin_ff[31:13]};
      fin_in    = fin_ff;
      case (state_ff)
         ST_RUN:  fin_in = fold ^ {16'd0, fold[31:16]};
         ST_MIX1: fin_in = fin_ff * MM_F1;
         ST_MIX2: fin_in = fin_shift * MM_F2;
         default: fin_in = fin_ff;
      endcase
   end

   // response valid
   always_comb begin
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         in_key_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_key_ff    <= in_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop_fire) begin
         hash_ff  <= new_h;
         total_ff <= new_t;
      end
      fin_ff <= fin_in;
      if (emit_load) begin
         rsp_hash_ff <= fin_ff ^ {16'd0, fin_ff[31:16]};
         rsp_len_ff  <= total_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign rsp_key_length = rsp_len_ff;

endmodule

`default_nettype wire

// File: hdl/murmur3_32_hash.sv
// top level of the streaming murmur3 x86 32-bit hash
//
// Keys arrive as little-endian 32-bit words, one request per cycle while
// req_ready is high; the front end masks and scrambles each word in a
// two-stage multiply pipeline and hands it through a four-entry queue to the
// back end, which folds one word per cycle into the running hash while it
// is in its run state. A request that ends a key holds the back end through
// the fold, the two avalanche multiply states and the load of the response
// register, and longer while a finished response waits on rsp_ready. The
// seed register is sampled when the first word of a key reaches the back end.
`default_nettype none

module murmur3_32_hash
   import mm3_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [31:0]  req_data_word,
   input  wire logic [2:0]   req_byte_count,
   input  wire logic         req_last,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [31:0]       rsp_hash_value,
   output logic [31:0]       rsp_key_length,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_seed
);

   logic [31:0]  seed_reg_ff, seed_reg_in;
   logic         push_valid, push_ready, pop_valid, pop_ready;
   mm3_item_type push_item, pop_item;

   // seed register, always writable
   assign csr_ready   = 1'b1;
   assign seed_reg_in = (csr_valid && csr_ready) ? csr_seed : seed_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_reg_ff <= '0;
      end else begin
         seed_reg_ff <= seed_reg_in;
      end
   end

   mm3_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   mm3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   mm3_back u_back (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_reg_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .rsp_key_length (rsp_key_length)
   );

endmodule

`default_nettype wire

// File: hdl/mm3_port_checker.sv
// port checker for the murmur3 hash block and its bind
`default_nettype none

module mm3_port_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_ready,
   input  wire logic [2:0]   req_byte_count,
   input  wire logic         req_last,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_ready,
   input  wire logic [31:0]  rsp_hash_value,
   input  wire logic [31:0]  rsp_key_length,
   input  wire logic         csr_ready
);

   logic [4:0] pending_ff, pending_in;
   logic       ends_key, req_fire, rsp_fire;

   // a request ends a key when last is set or the word is partial
   assign ends_key = req_last || (req_byte_count == 3'd1) || (req_byte_count == 3'd2)
                     || (req_byte_count == 3'd3);
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // keys ended but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if ((req_fire && ends_key) && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_fire && !(req_fire && ends_key)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value)
         && $stable(rsp_key_length))
      else $error("response changed while stalled");

   // reset empties the response register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // no response without a finished key behind it
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 5'd0)
      else $error("response without a finished key");

   // the seed port never stalls
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("seed port stalled");

endmodule

bind murmur3_32_hash mm3_port_checker u_mm3_port_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_byte_count (req_byte_count),
   .req_last       (req_last),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value),
   .rsp_key_length (rsp_key_length),
   .csr_ready      (csr_ready)
);

`default_nettype wire

// File: tb/tb_murmur3_32_hash.sv
// self-checking testbench for the streaming murmur3 x86 32-bit hash block
`default_nettype none

module tb_murmur3_32_hash;
   import mm3_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 205;
   localparam int N_DIRECTED   = 22;

   // kind of row in the directed table
   typedef enum logic {
      ROW_KEY,
      ROW_SEED
   } row_kind_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [31:0] key_length;
   } hash_result_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  data;
      logic [2:0]   nbytes;
      logic         last;
      logic         known;
      logic [31:0]  hash_value;
      logic [31:0]  key_length;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_hash_value;
   logic [31:0] rsp_key_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_seed = '0;

   // predictor state
   logic [31:0] seed_reg = '0;
   logic [31:0] run_hash = '0;
   logic [31:0] len_total = '0;
   logic        key_open = 1'b0;

   hash_result_type pending_hashes [$];
   int              mismatch_count = 0;
   int              words_sent = 0;
   int              rsp_wait = 0;
   int              idle_cycles = 0;
   logic            quiet = 1'b0;

   // directed stimulus: extremes, every byte count, each corner of key framing
   step_type directed_steps [0:N_DIRECTED-1] = '{
      // empty key right after reset hashes to zero
      '{ROW_KEY,  32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000, 32'd0},
      '{ROW_SEED, 32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'hffff_ffff, FULL_BYTES, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'h0000_0000, FULL_BYTES, 1'b1, 1'b0, 32'h0, 32'd0},
      // partial words close the key even without last
      '{ROW_KEY,  32'hffff_ffff, 3'd1, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'ha5a5_a5a5, 3'd2, 1'b1, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'hffff_ffff, 3'd3, 1'b0, 1'b0, 32'h0, 32'd0},
      // counts above four act as full words
      '{ROW_KEY,  32'h1234_5678, 3'd5, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'h9abc_def0, 3'd6, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'h0f1e_2d3c, 3'd7, 1'b1, 1'b0, 32'h0, 32'd0},
      // empty words without last open a key and add nothing
      '{ROW_KEY,  32'hdead_beef, 3'd0, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'h0102_0304, FULL_BYTES, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'hcafe_f00d, 3'd0, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0, 32'd0},
      '{ROW_SEED, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 32'h0, 32'd0},
      // empty key with zero seed, junk in the word
      '{ROW_KEY,  32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'h0000_0000, 32'd0},
      // seed written while a key is open applies to the next key
      '{ROW_KEY,  32'h8000_0001, FULL_BYTES, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_SEED, 32'h9747_b28c, 3'd0, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'h7fff_ffff, FULL_BYTES, 1'b1, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'h0000_ffff, FULL_BYTES, 1'b0, 1'b0, 32'h0, 32'd0},
      '{ROW_KEY,  32'hffff_0000, 3'd3, 1'b1, 1'b0, 32'h0, 32'd0}
   };

   murmur3_32_hash DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .rsp_key_length (rsp_key_length),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int r);
      return (v << r) | (v >> (32 - r));
   endfunction

   function automatic logic [31:0] scramble_word(input logic [31:0] k);
      logic [31:0] t;
      t = k * MM_C1;
      t = rotate_left(t, 15);
      return t * MM_C2;
   endfunction

   function automatic logic [31:0] final_mix(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * MM_F1;
      t = t ^ (t >> 13);
      t = t * MM_F2;
      return t ^ (t >> 16);
   endfunction

   // fold one request into the running hash; returns 1 when the key closes
   function automatic logic murmur_absorb(input logic [31:0] word, input logic [2:0] nbytes,
                                          input logic lst, output hash_result_type res);
      logic [2:0]  n;
      logic        closes;
      logic [31:0] h;
      n = (nbytes > FULL_BYTES) ? FULL_BYTES : nbytes;
      if (!key_open) begin
         run_hash  = seed_reg;
         len_total = '0;
         key_open  = 1'b1;
      end
      len_total = len_total + 32'(n);
      closes = lst;
      if (n == FULL_BYTES) begin
         h = rotate_left(run_hash ^ scramble_word(word), 13);
         run_hash = h * 32'd5 + MM_ADD;
      end else if (n != 3'd0) begin
         run_hash = run_hash ^ scramble_word(word & ((32'h1 << (8 * n)) - 32'h1));
         closes = 1'b1;
      end
      res.hash_value = final_mix(run_hash ^ len_total);
      res.key_length = len_total;
      if (closes)
         key_open = 1'b0;
      return closes;
   endfunction

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // drive one request and record its expected hash, if it closes a key
   task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes, input logic lst,
                            input logic use_typed, input hash_result_type typed);
      hash_result_type res;
      int              gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= nbytes;
      req_last       <= lst;
      do @(posedge clock); while (!req_ready);
      if (murmur_absorb(word, nbytes, lst, res))
         pending_hashes.insert(pending_hashes.size(), use_typed ? typed : res);
      words_sent++;
   endtask

   // seed write once the block has drained
   task automatic write_seed(input logic [31:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock); while (!csr_ready);
      seed_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one random key: full words with noise, then some way of ending it
   task automatic send_key();
      int nwords;
      int ending;
      logic [2:0] n;
      nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      for (int i = 0; i < nwords; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_word($urandom, 3'd0, 1'b0, 1'b0, '0);
         n = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : FULL_BYTES;
         send_word($urandom, n, ($urandom_range(0, 31) == 0), 1'b0, '0);
      end
      ending = $urandom_range(0, 9);
      if (ending <= 3)
         send_word($urandom, 3'($urandom_range(1, 3)), 1'($urandom_range(0, 1)), 1'b0, '0);
      else if (ending <= 6)
         send_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : FULL_BYTES,
                   1'b1, 1'b0, '0);
      else if (ending <= 8)
         send_word($urandom, 3'd0, 1'b1, 1'b0, '0);
      // otherwise leave the key open so the next one continues it
   endtask

   // response check
   always @(posedge clock) begin
      hash_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hashes.size() == 0) begin
            report_mismatch("unexpected response, hash", rsp_hash_value, 32'h0);
         end else begin
            want = pending_hashes.pop_front();
            if (rsp_hash_value !== want.hash_value)
               report_mismatch("hash_value", rsp_hash_value, want.hash_value);
            if (rsp_key_length !== want.key_length)
               report_mismatch("key_length", rsp_key_length, want.key_length);
         end
         rsp_wait = draw_gap();
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // main sequence
   initial begin
      logic [31:0] seed_value;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_SEED)
            write_seed(directed_steps[i].data);
         else
            send_word(directed_steps[i].data, directed_steps[i].nbytes, directed_steps[i].last,
                      directed_steps[i].known,
                      '{directed_steps[i].hash_value, directed_steps[i].key_length});
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1:       seed_value = 32'h0000_0000;
            2:       seed_value = 32'hffff_ffff;
            5:       seed_value = 32'h0000_0001;
            default: seed_value = $urandom;
         endcase
         write_seed(seed_value);
         quiet = (p == 3);
         while (words_sent < N_DIRECTED + (p + 1) * PHASE_WORDS) begin
            if (p != 3 && $urandom_range(0, 7) == 0)
               quiet = ~quiet;
            send_key();
         end
      end

      // close any open key, then drain
      send_word($urandom, 3'd0, 1'b1, 1'b0, '0);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// File: murmur3_32_hash.f
hdl/mm3_pkg.sv
hdl/mm3_front.sv
hdl/mm3_queue.sv
hdl/mm3_back.sv
hdl/murmur3_32_hash.sv
hdl/mm3_port_checker.sv
tb/tb_murmur3_32_hash.sv
